// ===== hw/rtl/msp_pkg.sv =====
// Shared types and constants for the multiplexed servo pulse ramp block.
`timescale 1ns / 1ps

package msp_pkg;

	localparam int unsigned WIDTH_W  = 16;
	localparam int unsigned CHAN_W   = 3;
	localparam int unsigned PINS     = 8;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [WIDTH_W-1:0]   width_t;
	typedef logic [CHAN_W-1:0]    chan_t;
	typedef logic [PINS-1:0]      pins_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOT_PERIOD   = 2'd0,
		REG_STEP_SIZE     = 2'd1,
		REG_RAMP_INTERVAL = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_TICK       = 1'b0,
		KIND_SET_TARGET = 1'b1
	} kind_t;

	localparam width_t SLOT_PERIOD_RST   = 16'd5000;
	localparam width_t STEP_SIZE_RST     = 16'd10;
	localparam width_t RAMP_INTERVAL_RST = 16'd1000;

endpackage

// ===== hw/rtl/msp_cmd_if.sv =====
// Command channel: timer tick or set-target item.
`timescale 1ns / 1ps

interface msp_cmd_if;
	logic              valid;
	logic              ready;
	logic              kind;
	msp_pkg::chan_t    channel;
	msp_pkg::width_t   target_width;

	modport source (output valid, kind, channel, target_width, input ready);
	modport sink   (input valid, kind, channel, target_width, output ready);
endinterface

// ===== hw/rtl/msp_rsp_if.sv =====
// Result channel: pin levels, active channel and moving flag.
`timescale 1ns / 1ps

interface msp_rsp_if;
	logic            valid;
	logic            ready;
	msp_pkg::pins_t  pin_levels;
	msp_pkg::chan_t  active_channel;
	logic            moving;

	modport source (output valid, pin_levels, active_channel, moving, input ready);
	modport sink   (input valid, pin_levels, active_channel, moving, output ready);
endinterface

// ===== hw/rtl/msp_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps

interface msp_cfg_if;
	logic               valid;
	logic               ready;
	msp_pkg::cfg_idx_t  index;
	msp_pkg::width_t    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/multiplexed_servo_pulse_ramp_core.sv =====
// Multiplexed servo pulse generator with concurrent width ramping.
// Latency: the result of an item is valid on the cycle after it is accepted.
// Throughput: one item per cycle; cmd.ready drops only while a result is held
//   in the output register and rsp.ready is low.
// Reset: arst_n clears all widths, targets, counters and the result valid flag
//   (the result data is not reset); configuration returns to 5000 / 10 / 1000.
`timescale 1ns / 1ps

module multiplexed_servo_pulse_ramp_core #(
	parameter int unsigned CHANNELS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	msp_cfg_if.sink    cfg,
	msp_cmd_if.sink    cmd,
	msp_rsp_if.source  rsp
);
	import msp_pkg::*;

	localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	// configuration
	width_t slot_period_q, step_size_q, ramp_interval_q;

	// state
	logic [CH_W-1:0] cur_q;
	width_t          slot_cnt_q;
	logic            pulse_q;
	width_t          ramp_cnt_q;
	width_t          width_q  [CHANNELS];
	width_t          target_q [CHANNELS];

	// result register
	logic   rsp_valid_q;
	pins_t  pins_q;
	chan_t  active_q;
	logic   moving_q;

	// next state
	logic            cmd_fire, is_tick, do_ramp;
	width_t          period, interval, period_lim, eff;
	logic [WIDTH_W:0] slot_inc, ramp_inc;
	logic            pulse_t, pulse_d;
	logic [CH_W-1:0] cur_t, cur_d;
	width_t          slot_d, ramp_d;
	width_t          width_d  [CHANNELS];
	width_t          target_d [CHANNELS];
	logic [WIDTH_W:0] up_sum  [CHANNELS];
	width_t          up_w     [CHANNELS];
	width_t          dn_w     [CHANNELS];
	logic            moving_d;
	pins_t           pins_d;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign is_tick   = (cmd.kind == KIND_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_period_q   <= SLOT_PERIOD_RST;
			step_size_q     <= STEP_SIZE_RST;
			ramp_interval_q <= RAMP_INTERVAL_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_SLOT_PERIOD:   slot_period_q   <= cfg.data;
				REG_STEP_SIZE:     step_size_q     <= cfg.data;
				REG_RAMP_INTERVAL: ramp_interval_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// slot timing
	always_comb begin
		period     = (slot_period_q == '0) ? WIDTH_W'(1) : slot_period_q;
		interval   = (ramp_interval_q == '0) ? WIDTH_W'(1) : ramp_interval_q;
		period_lim = period - WIDTH_W'(1);
		eff        = (width_q[cur_q] > period_lim) ? period_lim : width_q[cur_q];

		pulse_t = pulse_q;
		cur_t   = cur_q;
		if (slot_cnt_q == '0)
			pulse_t = 1'b1;
		if (pulse_t && (slot_cnt_q >= eff)) begin
			pulse_t = 1'b0;
			cur_t   = (cur_q == LAST_CH) ? '0 : cur_q + 1'b1;
		end

		slot_inc = {1'b0, slot_cnt_q} + 1'b1;
		slot_d   = (slot_inc >= {1'b0, period}) ? '0 : slot_inc[WIDTH_W-1:0];
		ramp_inc = {1'b0, ramp_cnt_q} + 1'b1;
		do_ramp  = is_tick && (ramp_inc >= {1'b0, interval});
		ramp_d   = do_ramp ? '0 : ramp_inc[WIDTH_W-1:0];

		pulse_d = is_tick ? pulse_t : pulse_q;
		cur_d   = is_tick ? cur_t : cur_q;
	end

	// all channels ramp in parallel
	always_comb begin
		moving_d = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			up_sum[c]   = {1'b0, width_q[c]} + {1'b0, step_size_q};
			up_w[c]     = up_sum[c][WIDTH_W] ? '1 : up_sum[c][WIDTH_W-1:0];
			dn_w[c]     = (width_q[c] > step_size_q) ? width_q[c] - step_size_q : '0;
			width_d[c]  = width_q[c];
			target_d[c] = target_q[c];
			if (do_ramp) begin
				if (width_q[c] < target_q[c]) begin
					width_d[c] = up_w[c];
					if (up_w[c] >= target_q[c])
						target_d[c] = up_w[c];
				end else if (width_q[c] > target_q[c]) begin
					width_d[c] = dn_w[c];
					if (dn_w[c] <= target_q[c])
						target_d[c] = dn_w[c];
				end
			end
			if (!is_tick && (5'(cmd.channel) == 5'(c)))
				target_d[c] = cmd.target_width;
			if (width_d[c] != target_d[c])
				moving_d = 1'b1;
		end
		for (int i = 0; i < PINS; i++)
			pins_d[i] = pulse_d && (5'(cur_d) == 5'(i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			slot_cnt_q <= '0;
			pulse_q    <= 1'b0;
			ramp_cnt_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				width_q[c]  <= '0;
				target_q[c] <= '0;
			end
		end else if (cmd_fire) begin
			cur_q   <= cur_d;
			pulse_q <= pulse_d;
			if (is_tick) begin
				slot_cnt_q <= slot_d;
				ramp_cnt_q <= ramp_d;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				width_q[c]  <= width_d[c];
				target_q[c] <= target_d[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			rsp_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			pins_q   <= pins_d;
			active_q <= CHAN_W'(cur_d);
			moving_q <= moving_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.pin_levels     = pins_q;
	assign rsp.active_channel = active_q;
	assign rsp.moving         = moving_q;

endmodule

// ===== hw/rtl/msp_checker.sv =====
// Port-level assertions for the servo pulse ramp core, with its bind.
`timescale 1ns / 1ps

module msp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input msp_pkg::pins_t  pin_levels,
	input msp_pkg::chan_t  active_channel,
	input logic            moving
);
	import msp_pkg::*;

	// every accepted item yields a result on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> rsp_valid)
		else $error("accepted item produced no result");

	// no new item while a result is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !cmd_ready)
		else $error("item accepted over a stalled result");

	// at most one pin high, and only the active one
	a_pin_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0(pin_levels))
		else $error("more than one pin high");

	a_pin_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (pin_levels != '0) |-> pin_levels == (pins_t'(1) << active_channel))
		else $error("pin high outside the active slot");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pin_levels)
			&& $stable(active_channel) && $stable(moving))
		else $error("stalled result changed");

endmodule

bind multiplexed_servo_pulse_ramp_core msp_checker u_msp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.pin_levels     (rsp.pin_levels),
	.active_channel (rsp.active_channel),
	.moving         (rsp.moving)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the multiplexed servo pulse ramp core.
`timescale 1ns / 1ps

module testbench;
	import msp_pkg::*;

	localparam int unsigned NUM_SERVOS = 8;

	typedef struct packed {
		pins_t pins;
		chan_t chan;
		logic  moving;
	} servo_out_t;

	class servo_scoreboard;
		width_t     period_r;
		width_t     step_r;
		width_t     interval_r;
		chan_t      cur_chan;
		width_t     slot_cnt;
		bit         pulse_on;
		width_t     widths[NUM_SERVOS];
		width_t     targets[NUM_SERVOS];
		width_t     ramp_cnt;
		servo_out_t expected_outputs[$];
		int         errors;

		function new();
			period_r   = SLOT_PERIOD_RST;
			step_r     = STEP_SIZE_RST;
			interval_r = RAMP_INTERVAL_RST;
			cur_chan   = '0;
			slot_cnt   = '0;
			pulse_on   = 1'b0;
			ramp_cnt   = '0;
			errors     = 0;
			for (int c = 0; c < NUM_SERVOS; c++) begin
				widths[c]  = '0;
				targets[c] = '0;
			end
		endfunction

		function void write_reg(cfg_reg_t idx, width_t val);
			case (idx)
				REG_SLOT_PERIOD:   period_r = val;
				REG_STEP_SIZE:     step_r = val;
				REG_RAMP_INTERVAL: interval_r = val;
				default: ;
			endcase
		endfunction

		// all channels step toward their targets; reaching or passing parks the target there
		function void ramp_widths();
			logic [16:0] w;
			for (int c = 0; c < NUM_SERVOS; c++) begin
				w = {1'b0, widths[c]};
				if (widths[c] < targets[c]) begin
					w = widths[c] + step_r;
					if (w > 17'h0FFFF) w = 17'h0FFFF;
					if (w >= targets[c]) targets[c] = w[15:0];
				end else if (widths[c] > targets[c]) begin
					w = (widths[c] > step_r) ? widths[c] - step_r : 17'd0;
					if (w <= targets[c]) targets[c] = w[15:0];
				end
				widths[c] = w[15:0];
			end
		endfunction

		function void servo_tick();
			logic [16:0] per;
			logic [16:0] ivl;
			logic [16:0] nxt;
			logic [16:0] lim;
			per = (period_r == 0) ? 17'd1 : {1'b0, period_r};
			ivl = (interval_r == 0) ? 17'd1 : {1'b0, interval_r};
			lim = {1'b0, widths[cur_chan]};
			if (lim > per - 1) lim = per - 1;
			if (slot_cnt == 0) pulse_on = 1'b1;
			if (pulse_on && slot_cnt >= lim) begin
				pulse_on = 1'b0;
				cur_chan = (cur_chan == chan_t'(NUM_SERVOS - 1)) ? '0 : cur_chan + 1'b1;
			end
			nxt = slot_cnt + 1;
			slot_cnt = (nxt >= per) ? '0 : nxt[15:0];
			nxt = ramp_cnt + 1;
			if (nxt >= ivl) begin
				ramp_cnt = '0;
				ramp_widths();
			end else begin
				ramp_cnt = nxt[15:0];
			end
		endfunction

		function void note_cmd(kind_t kind, chan_t ch, width_t tw);
			servo_out_t e;
			bit mv;
			if (kind == KIND_TICK) servo_tick();
			else if (ch < NUM_SERVOS) targets[ch] = tw;
			mv = 1'b0;
			for (int c = 0; c < NUM_SERVOS; c++)
				if (widths[c] != targets[c]) mv = 1'b1;
			e.pins   = pulse_on ? (pins_t'(1) << cur_chan) : '0;
			e.chan   = cur_chan;
			e.moving = mv;
			expected_outputs.push_back(e);
		endfunction

		function int pending();
			return expected_outputs.size();
		endfunction

		task report(string what, int got, int want);
			if (errors < 40)
				$display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
			errors++;
		endtask

		task check_rsp(pins_t p, chan_t a, logic m);
			servo_out_t e;
			if (expected_outputs.size() == 0) begin
				report("unexpected item, pin_levels", p, 0);
			end else begin
				e = expected_outputs.pop_front();
				if (p !== e.pins) report("pin_levels", p, e.pins);
				if (a !== e.chan) report("active_channel", a, e.chan);
				if (m !== e.moving) report("moving", m, e.moving);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	logic stall_go;
	logic stall_done;

	servo_scoreboard sb = new();

	msp_cfg_if cfg_bus();
	msp_cmd_if cmd_bus();
	msp_rsp_if rsp_bus();

	multiplexed_servo_pulse_ramp_core #(.CHANNELS(NUM_SERVOS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus.sink),
		.cmd    (cmd_bus.sink),
		.rsp    (rsp_bus.source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				sb.write_reg(cfg_reg_t'(cfg_bus.index), cfg_bus.data);
			if (cmd_bus.valid && cmd_bus.ready)
				sb.note_cmd(kind_t'(cmd_bus.kind), cmd_bus.channel, cmd_bus.target_width);
			if (rsp_bus.valid && rsp_bus.ready)
				sb.check_rsp(rsp_bus.pin_levels, rsp_bus.active_channel, rsp_bus.moving);
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		rsp_bus.ready = 1'b0;
		stall_done = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_go && !stall_done) begin
				rsp_bus.ready <= 1'b0;
				repeat (300) @(posedge clk);
				stall_done = 1'b1;
			end else begin
				if (!stall_go) stall_done = 1'b0;
				rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task send_command(kind_t kind, chan_t ch, width_t tw);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid        <= 1'b1;
		cmd_bus.kind         <= kind;
		cmd_bus.channel      <= ch;
		cmd_bus.target_width <= tw;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
	endtask

	task set_config(width_t sp, width_t ss, width_t ri);
		cfg_reg_t regs[3];
		width_t   vals[3];
		regs = '{REG_SLOT_PERIOD, REG_STEP_SIZE, REG_RAMP_INTERVAL};
		vals = '{sp, ss, ri};
		for (int i = 0; i < 3; i++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= regs[i];
			cfg_bus.data  <= vals[i];
			@(posedge clk);
			while (!cfg_bus.ready) @(posedge clk);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	task wait_idle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly ticks; half of the targets within span, a quarter full range, a quarter extreme
	task run_servo_traffic(int count, int span);
		width_t tw;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 72) begin
				send_command(KIND_TICK, chan_t'($urandom_range(7)), width_t'($urandom));
			end else begin
				case ($urandom_range(3))
					0, 1: tw = width_t'($urandom_range(span));
					2: tw = width_t'($urandom);
					default: tw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				endcase
				send_command(KIND_SET_TARGET, chan_t'($urandom_range(7)), tw);
			end
		end
		cmd_bus.valid <= 1'b0;
	endtask

	task run_phase(width_t sp, width_t ss, width_t ri, int s_pct, int r_pct, int count,
			int span);
		wait_idle();
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		set_config(sp, ss, ri);
		run_servo_traffic(count, span);
	endtask

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		stall_go = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_SLOT_PERIOD;
		cfg_bus.data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.kind = KIND_TICK;
		cmd_bus.channel = '0;
		cmd_bus.target_width = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero widths, extreme targets, ramp up and down
		set_config(16'd4, 16'd3, 16'd2);
		send_command(KIND_TICK, 3'd0, 16'h0000);
		send_command(KIND_TICK, 3'd7, 16'hFFFF);
		send_command(KIND_SET_TARGET, 3'd0, 16'hFFFF);
		send_command(KIND_SET_TARGET, 3'd7, 16'hFFFF);
		send_command(KIND_SET_TARGET, 3'd1, 16'd5);
		send_command(KIND_SET_TARGET, 3'd3, 16'd1);
		repeat (10) send_command(KIND_TICK, 3'd5, 16'h5555);
		send_command(KIND_SET_TARGET, 3'd0, 16'h0000);
		send_command(KIND_SET_TARGET, 3'd7, 16'd2);
		repeat (6) send_command(KIND_TICK, 3'd2, 16'hAAAA);
		cmd_bus.valid <= 1'b0;

		run_phase(16'd7, 16'd5, 16'd3, 10, 79, 380, 16);
		run_phase(16'd1, 16'hFFFF, 16'd1, 79, 10, 250, 8);
		run_phase(16'hFFFF, 16'd1, 16'd1, 0, 0, 300, 400);
		run_phase(16'd12, 16'd3, 16'hFFFF, 0, 0, 200, 30);

		// block fills while results are held off, then a full drain mid-phase
		wait_idle();
		set_config(16'd20, 16'd7, 16'd4);
		fork
			begin
				run_servo_traffic(175, 40);
				wait_idle();
				run_servo_traffic(175, 40);
			end
			begin
				repeat (20) @(posedge clk);
				stall_go <= 1'b1;
				wait (stall_done);
				stall_go <= 1'b0;
			end
		join

		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) sb.report("items never returned", sb.pending(), 0);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/msp_pkg.sv
hw/rtl/msp_cmd_if.sv
hw/rtl/msp_rsp_if.sv
hw/rtl/msp_cfg_if.sv
hw/rtl/multiplexed_servo_pulse_ramp_core.sv
hw/rtl/msp_checker.sv
test/testbench.sv
